// ----- rtl/sdspi_pkg.sv -----
package sdspi_pkg;

    // Input opcodes
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_RX   = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_INIT_RETRIES = 3'd0;
    localparam logic [2:0] REG_MMC_TRY_AT   = 3'd1;
    localparam logic [2:0] REG_TOKEN_POLLS  = 3'd2;
    localparam logic [2:0] REG_SLOW_DIV     = 3'd3;
    localparam logic [2:0] REG_FAST_DIV     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOINIT  = 2'd1;
    localparam logic [1:0] ST_RDERR   = 2'd2;
    localparam logic [1:0] ST_BADREQ  = 2'd3;

    // Command indexes
    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD1  = 6'd1;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD16 = 6'd16;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam logic [9:0] BLOCK_BYTES  = 10'd512;
    localparam logic [9:0] FRAME_BYTES  = 10'd514;
    localparam logic [7:0] IDLE_BYTE    = 8'hFF;
    localparam logic [7:0] TOKEN_BYTE   = 8'hFE;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_WAKE      = 9'b000000010,
        PH_CMD       = 9'b000000100,
        PH_RESP      = 9'b000001000,
        PH_OCR       = 9'b000010000,
        PH_TOKEN     = 9'b000100000,
        PH_DATA      = 9'b001000000,
        PH_TRAIL_OK  = 9'b010000000,
        PH_TRAIL_ERR = 9'b100000000
    } phase_t;

    // Accepted input item
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sector;
        logic [8:0]  byte_offset;
        logic [9:0]  byte_count;
        logic [7:0]  rx_byte;
    } item_t;

    // Result item
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_high;
        logic [7:0] clock_divider;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       last_data;
        logic       done_res;
        logic [1:0] status;
        logic [1:0] card_kind;
    } result_t;

    // Configuration registers
    typedef struct packed {
        logic [19:0] init_retries;
        logic [19:0] mmc_try_at;
        logic [19:0] token_polls;
        logic [7:0]  slow_divider;
        logic [7:0]  fast_divider;
    } cfg_t;

    // Command frame byte at a given position
    function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [2:0] pos,
                                              input logic v2, input logic [31:0] rd_arg);
        logic [31:0] a;
        logic [7:0]  b;
        begin
            case (idx)
                CMD8:    a = 32'h0000_01AA;
                CMD41:   a = v2 ? 32'h4000_0000 : 32'h0;
                CMD16:   a = 32'd512;
                CMD17:   a = rd_arg;
                default: a = 32'h0;
            endcase
            case (pos)
                3'd0:    b = 8'hFF;
                3'd1:    b = {2'b01, idx};
                3'd2:    b = a[31:24];
                3'd3:    b = a[23:16];
                3'd4:    b = a[15:8];
                3'd5:    b = a[7:0];
                default: b = (idx == CMD0) ? 8'h95 : ((idx == CMD8) ? 8'h87 : 8'h01);
            endcase
            return b;
        end
    endfunction

endpackage

// ----- rtl/sdspi_cfg.sv -----
module sdspi_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    output sdspi_pkg::cfg_t    cfg
);
    import sdspi_pkg::*;

    cfg_t cfg_reg;

    // Register file with reset defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_retries <= 20'd200000;
            cfg_reg.mmc_try_at   <= 20'd100000;
            cfg_reg.token_polls  <= 20'd400000;
            cfg_reg.slow_divider <= 8'd62;
            cfg_reg.fast_divider <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INIT_RETRIES: cfg_reg.init_retries <= cfg_data;
                REG_MMC_TRY_AT:   cfg_reg.mmc_try_at   <= cfg_data;
                REG_TOKEN_POLLS:  cfg_reg.token_polls  <= cfg_data;
                REG_SLOW_DIV:     cfg_reg.slow_divider <= cfg_data[7:0];
                REG_FAST_DIV:     cfg_reg.fast_divider <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/sdspi_seq.sv -----
module sdspi_seq #(
    parameter int RESPONSE_POLLS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  sdspi_pkg::item_t     item,
    input  sdspi_pkg::cfg_t      cfg,
    output logic                 has_result,
    output sdspi_pkg::result_t   result
);
    import sdspi_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  flags_reg, flags_next;
    logic [9:0]  bcnt_reg, bcnt_next;
    logic [19:0] retry_reg, retry_next;
    logic [3:0]  polls_reg, polls_next;
    logic [5:0]  cidx_reg, cidx_next;
    logic [31:0] carg_reg, carg_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic        app_reg, app_next;
    logic [9:0]  skip_reg, skip_next;
    logic [9:0]  left_reg, left_next;
    logic        hs_reg, hs_next;

    logic        txv, dv, last, done;
    logic [7:0]  tx, db;
    logic [1:0]  st;
    logic [10:0] req_sum;
    logic [19:0] ret_dec;
    logic [31:0] ocr_word;
    logic [2:0]  fpos_inc;
    logic        resp_now;

    // One transaction's worth of sequencing
    always_comb
    begin
        phase_next = phase_reg; flags_next = flags_reg; bcnt_next = bcnt_reg;
        retry_next = retry_reg; polls_next = polls_reg; cidx_next = cidx_reg;
        carg_next = carg_reg; fpos_next = fpos_reg; app_next = app_reg;
        skip_next = skip_reg; left_next = left_reg; hs_next = hs_reg;
        txv = 1'b0; tx = 8'h00; dv = 1'b0; db = 8'h00; last = 1'b0;
        done = 1'b0; st = ST_OK; has_result = 1'b1;
        req_sum  = {2'b00, item.byte_offset} + {1'b0, item.byte_count};
        ret_dec  = retry_reg - 20'd1;
        ocr_word = {carg_reg[23:0], item.rx_byte};
        fpos_inc = fpos_reg + 3'd1;
        resp_now = !item.rx_byte[7] || (polls_reg >= 4'(RESPONSE_POLLS));

        if (item.opcode == OP_INIT || item.opcode == OP_READ)
        begin
            if (phase_reg != PH_IDLE)
            begin
                done = 1'b1; st = ST_BADREQ;
            end
            else if (item.opcode == OP_INIT)
            begin
                flags_next = 2'b00; hs_next = 1'b0; phase_next = PH_WAKE;
                bcnt_next = 10'd1; txv = 1'b1; tx = IDLE_BYTE;
            end
            else if (req_sum > {1'b0, BLOCK_BYTES})
            begin
                done = 1'b1; st = ST_BADREQ;
            end
            else if (!hs_reg)
            begin
                done = 1'b1; st = ST_NOINIT;
            end
            else
            begin
                skip_next = {1'b0, item.byte_offset};
                left_next = item.byte_count;
                carg_next = flags_reg[1] ? item.sector : {item.sector[22:0], 9'd0};
                cidx_next = CMD17; fpos_next = 3'd0; phase_next = PH_CMD;
                txv = 1'b1; tx = IDLE_BYTE;
            end
        end
        else if (item.opcode == OP_RX && phase_reg != PH_IDLE)
        begin
            case (phase_reg)
                PH_WAKE:
                begin
                    txv = 1'b1; tx = IDLE_BYTE;
                    if (bcnt_reg < 10'd10)
                        bcnt_next = bcnt_reg + 10'd1;
                    else
                    begin
                        cidx_next = CMD0; fpos_next = 3'd0; phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    txv = 1'b1;
                    if (fpos_inc < 3'd7)
                    begin
                        fpos_next = fpos_inc;
                        tx = frame_byte(cidx_reg, fpos_inc, flags_reg[0], carg_reg);
                    end
                    else
                    begin
                        fpos_next = 3'd0; phase_next = PH_RESP; polls_next = 4'd1;
                        tx = IDLE_BYTE;
                    end
                end
                PH_RESP:
                begin
                    if (!resp_now)
                    begin
                        polls_next = polls_reg + 4'd1; txv = 1'b1; tx = IDLE_BYTE;
                    end
                    else
                    begin
                        // Start-command defaults; overridden below where needed
                        txv = 1'b1; tx = IDLE_BYTE;
                        fpos_next = 3'd0;
                        case (cidx_reg)
                            CMD0:
                                if (item.rx_byte == 8'h01)
                                begin
                                    cidx_next = CMD8; phase_next = PH_CMD;
                                end
                                else
                                begin
                                    txv = 1'b0; tx = 8'h00; hs_next = 1'b0;
                                    phase_next = PH_IDLE; done = 1'b1; st = ST_NOINIT;
                                end
                            CMD8:
                                if (item.rx_byte == 8'h01)
                                begin
                                    phase_next = PH_OCR; bcnt_next = 10'd0; carg_next = 32'd0;
                                end
                                else if (cfg.init_retries == 20'd0)
                                begin
                                    retry_next = 20'd0; txv = 1'b0; tx = 8'h00;
                                    hs_next = 1'b0; phase_next = PH_IDLE;
                                    done = 1'b1; st = ST_NOINIT;
                                end
                                else
                                begin
                                    retry_next = cfg.init_retries; app_next = 1'b1;
                                    cidx_next = CMD55; phase_next = PH_CMD;
                                end
                            CMD55, CMD41, CMD1:
                            begin
                                if (cidx_reg == CMD55 && !app_reg)
                                begin
                                    txv = 1'b0; tx = 8'h00; hs_next = 1'b0;
                                    phase_next = PH_IDLE; done = 1'b1; st = ST_NOINIT;
                                end
                                else if (cidx_reg == CMD55 && item.rx_byte <= 8'h01)
                                begin
                                    app_next = 1'b0; cidx_next = CMD41; phase_next = PH_CMD;
                                end
                                else
                                begin
                                    if (cidx_reg == CMD55) app_next = 1'b0;
                                    if (item.rx_byte == 8'h00)
                                    begin
                                        phase_next = PH_CMD;
                                        cidx_next = (cidx_reg == CMD1) ? CMD16 :
                                                    (flags_reg[0] ? CMD58 : CMD16);
                                    end
                                    else if (cidx_reg != CMD1 && !flags_reg[0] &&
                                             retry_reg == cfg.mmc_try_at)
                                    begin
                                        cidx_next = CMD1; phase_next = PH_CMD;
                                    end
                                    else
                                    begin
                                        retry_next = ret_dec;
                                        if (ret_dec == 20'd0)
                                        begin
                                            txv = 1'b0; tx = 8'h00; hs_next = 1'b0;
                                            phase_next = PH_IDLE; done = 1'b1;
                                            st = ST_NOINIT;
                                        end
                                        else
                                        begin
                                            app_next = 1'b1; cidx_next = CMD55;
                                            phase_next = PH_CMD;
                                        end
                                    end
                                end
                            end
                            CMD58:
                                if (item.rx_byte == 8'h00)
                                begin
                                    phase_next = PH_OCR; bcnt_next = 10'd0; carg_next = 32'd0;
                                end
                                else
                                begin
                                    txv = 1'b0; tx = 8'h00; hs_next = 1'b0;
                                    phase_next = PH_IDLE; done = 1'b1; st = ST_NOINIT;
                                end
                            CMD16:
                            begin
                                txv = 1'b0; tx = 8'h00; phase_next = PH_IDLE; done = 1'b1;
                                hs_next = (item.rx_byte == 8'h00);
                                st = (item.rx_byte == 8'h00) ? ST_OK : ST_NOINIT;
                            end
                            CMD17:
                                if (item.rx_byte != 8'h00 || cfg.token_polls == 20'd0)
                                    phase_next = PH_TRAIL_ERR;
                                else
                                begin
                                    phase_next = PH_TOKEN; retry_next = cfg.token_polls;
                                end
                            default:
                            begin
                                txv = 1'b0; tx = 8'h00; hs_next = 1'b0;
                                phase_next = PH_IDLE; done = 1'b1; st = ST_NOINIT;
                            end
                        endcase
                    end
                end
                PH_OCR:
                begin
                    carg_next = ocr_word;
                    bcnt_next = bcnt_reg + 10'd1;
                    if (bcnt_reg + 10'd1 < 10'd4)
                    begin
                        txv = 1'b1; tx = IDLE_BYTE;
                    end
                    else if (cidx_reg == CMD8)
                    begin
                        if (ocr_word[15:0] != 16'h01AA)
                        begin
                            hs_next = 1'b0; phase_next = PH_IDLE; done = 1'b1; st = ST_NOINIT;
                        end
                        else
                        begin
                            flags_next = 2'b01;
                            retry_next = cfg.init_retries;
                            if (cfg.init_retries == 20'd0)
                            begin
                                hs_next = 1'b0; phase_next = PH_IDLE;
                                done = 1'b1; st = ST_NOINIT;
                            end
                            else
                            begin
                                app_next = 1'b1; cidx_next = CMD55; fpos_next = 3'd0;
                                phase_next = PH_CMD; txv = 1'b1; tx = IDLE_BYTE;
                            end
                        end
                    end
                    else
                    begin
                        if (ocr_word[30]) flags_next = flags_reg | 2'b10;
                        hs_next = 1'b1; phase_next = PH_IDLE; done = 1'b1; st = ST_OK;
                    end
                end
                PH_TOKEN:
                begin
                    txv = 1'b1; tx = IDLE_BYTE;
                    if (item.rx_byte == TOKEN_BYTE)
                    begin
                        phase_next = PH_DATA; bcnt_next = FRAME_BYTES;
                    end
                    else
                    begin
                        retry_next = ret_dec;
                        if (ret_dec == 20'd0) phase_next = PH_TRAIL_ERR;
                    end
                end
                PH_DATA:
                begin
                    if (skip_reg != 10'd0)
                        skip_next = skip_reg - 10'd1;
                    else if (left_reg != 10'd0)
                    begin
                        left_next = left_reg - 10'd1;
                        dv = 1'b1; db = item.rx_byte;
                        last = (left_reg == 10'd1);
                    end
                    bcnt_next = bcnt_reg - 10'd1;
                    if (bcnt_reg == 10'd1) phase_next = PH_TRAIL_OK;
                    txv = 1'b1; tx = IDLE_BYTE;
                end
                PH_TRAIL_OK:
                begin
                    phase_next = PH_IDLE; done = 1'b1; st = ST_OK;
                end
                PH_TRAIL_ERR:
                begin
                    phase_next = PH_IDLE; done = 1'b1; st = ST_RDERR;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        else
            has_result = 1'b0;

        result.tx_valid      = txv;
        result.tx_byte       = tx;
        result.select_high   = (phase_next == PH_WAKE) || (phase_next == PH_IDLE && !hs_next);
        result.clock_divider = hs_next ? cfg.fast_divider : cfg.slow_divider;
        result.data_valid    = dv;
        result.data_byte     = db;
        result.last_data     = last;
        result.done_res      = done;
        result.status        = st;
        result.card_kind     = flags_next;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; flags_reg <= '0; bcnt_reg <= '0; retry_reg <= '0;
            polls_reg <= '0; cidx_reg <= '0; carg_reg <= '0; fpos_reg <= '0;
            app_reg <= 1'b0; skip_reg <= '0; left_reg <= '0; hs_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; flags_reg <= flags_next; bcnt_reg <= bcnt_next;
            retry_reg <= retry_next; polls_reg <= polls_next; cidx_reg <= cidx_next;
            carg_reg <= carg_next; fpos_reg <= fpos_next; app_reg <= app_next;
            skip_reg <= skip_next; left_reg <= left_next; hs_reg <= hs_next;
        end
    end

endmodule

// ----- rtl/sd_spi_init_and_block_read_unit.sv -----
// Channel | Direction | Payload
// s_axis  | in        | tuser: opcode; tdata: sector, byte_offset, byte_count, rx_byte
// m_axis  | out       | tdata: tx_valid .. card_kind (see port comment); tlast: last_data
// cfg     | in        | we, index 0..4, 20-bit data
// One input transaction is registered, then processed combinationally into
// the output register; a new transaction can be taken every cycle while the output is not stalled.
// The result is valid once the transaction has passed the input and then the output register.
// Reset clears the sequencer to idle and loads the register defaults.
// Output stalls back up through the output and input registers only.
module sd_spi_init_and_block_read_unit #(
    parameter int RESPONSE_POLLS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // sector[31:0], byte_offset[40:32], byte_count[50:41], rx_byte[58:51]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_valid[0], tx_byte[8:1], select_high[9], clock_divider[17:10], data_valid[18],
    // data_byte[26:19], done_res[27], status[29:28], card_kind[31:30]
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import sdspi_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    logic    has_result;
    result_t res;
    logic    out_valid_reg;
    logic [31:0] out_reg;
    logic    last_reg;
    logic    out_free, step;

    sdspi_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    // Processing happens when the output stage can take the result
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || step;

    sdspi_seq #(.RESPONSE_POLLS(RESPONSE_POLLS)) u_seq (
        .clk(clk), .rst_n(rst_n), .step(step), .item(in_reg), .cfg(cfg),
        .has_result(has_result), .result(res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.opcode      <= s_axis_tuser;
            in_reg.sector      <= s_axis_tdata[31:0];
            in_reg.byte_offset <= s_axis_tdata[40:32];
            in_reg.byte_count  <= s_axis_tdata[50:41];
            in_reg.rx_byte     <= s_axis_tdata[58:51];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && has_result;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg  <= {res.card_kind, res.status, res.done_res,
                         res.data_byte, res.data_valid, res.clock_divider,
                         res.select_high, res.tx_byte, res.tx_valid};
            last_reg <= res.last_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = last_reg;

endmodule
